// ===== sv/rotary_push_event_classifier_top_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ROTARY_PUSH_EVENT_CLASSIFIER_TOP_MACROS_SVH
`define ROTARY_PUSH_EVENT_CLASSIFIER_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RPEC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true outside reset
`define RPEC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/rpec_pkg.sv =====
// Shared types and constants for the rotary push event classifier.
// No dependencies.
package rpec_pkg;

  typedef enum logic [2:0] {
    EV_PRESSED        = 3'd0,
    EV_RELEASED_SHORT = 3'd1,
    EV_RELEASED_LONG  = 3'd2,
    EV_RELEASED       = 3'd3,
    EV_TURNED         = 3'd4
  } event_e;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned StepsW = 15;

  localparam logic [CfgW-1:0] ShortLimitRst = 16'd400;
  localparam logic [CfgW-1:0] DeadTimeRst   = 16'd800;

  // register index within the config space
  localparam logic RegShortLimit = 1'b0;
  localparam logic RegDeadTime   = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one classified input item: an optional button event and an optional turn
  typedef struct packed {
    logic                     btn_vld;
    event_e                   btn_code;
    logic                     turn;
    logic signed [CountW-1:0] delta;
  } desc_t;

  // queue to back end handshake
  typedef struct packed {
    logic  vld;
    desc_t desc;
  } q_out_t;

endpackage

// ===== sv/rpec_front.sv =====
// Front end: accepts samples, tracks button/encoder state, classifies events.
// Depends on rpec_pkg.
module rpec_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic [rpec_pkg::TimeW-1:0]       now_ms_i,
  input  logic                             button_level_i,
  input  logic [rpec_pkg::CountW-1:0]      encoder_count_i,
  input  logic [rpec_pkg::CfgW-1:0]        short_limit_i,
  input  logic [rpec_pkg::CfgW-1:0]        dead_time_i,
  output logic                             desc_push_o,
  output rpec_pkg::desc_t                  desc_o
);

  logic                        held_q, held_d;
  logic [rpec_pkg::TimeW-1:0]  last_change_q, last_change_d;
  logic [rpec_pkg::TimeW-1:0]  last_edge_q, last_edge_d;
  logic [rpec_pkg::CountW-1:0] prev_count_q, prev_count_d;

  logic                        accept;
  logic                        press, release_ev, edge_ev, cnt_chg, is_short, turn_ok;
  logic [rpec_pkg::TimeW-1:0]  held_time, since_edge;

  assign accept     = push_i && !full_i;
  assign press      = !held_q && !button_level_i;
  assign release_ev = held_q && button_level_i;
  assign edge_ev    = press || release_ev;
  assign cnt_chg    = encoder_count_i != prev_count_q;
  assign held_time  = now_ms_i - last_change_q;
  assign since_edge = now_ms_i - last_edge_q;
  assign is_short   = held_time < {{(rpec_pkg::TimeW-rpec_pkg::CfgW){1'b0}}, short_limit_i};
  // an edge in the same sample restarts dead time, so no turn can be reported then
  assign turn_ok    = cnt_chg && !edge_ev &&
                      (since_edge > {{(rpec_pkg::TimeW-rpec_pkg::CfgW){1'b0}}, dead_time_i});

  always_comb begin
    held_d        = held_q;
    last_change_d = last_change_q;
    last_edge_d   = last_edge_q;
    prev_count_d  = prev_count_q;
    if (accept) begin
      if (press) begin
        held_d = 1'b1;
      end else if (release_ev) begin
        held_d = 1'b0;
      end
      if (edge_ev || cnt_chg) begin
        last_change_d = now_ms_i;
      end
      if (edge_ev) begin
        last_edge_d = now_ms_i;
      end
      prev_count_d = encoder_count_i;
    end
  end

  always_comb begin
    desc_o.btn_vld  = edge_ev;
    desc_o.btn_code = press ? rpec_pkg::EV_PRESSED :
                      (is_short ? rpec_pkg::EV_RELEASED_SHORT : rpec_pkg::EV_RELEASED_LONG);
    desc_o.turn     = turn_ok;
    desc_o.delta    = signed'(encoder_count_i - prev_count_q);
    desc_push_o     = accept && (edge_ev || turn_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      last_change_q <= '0;
      last_edge_q   <= '0;
      prev_count_q  <= '0;
    end else begin
      held_q        <= held_d;
      last_change_q <= last_change_d;
      last_edge_q   <= last_edge_d;
      prev_count_q  <= prev_count_d;
    end
  end

endmodule

// ===== sv/rpec_fifo.sv =====
// Short descriptor queue between front and back end.
// Depends on rpec_pkg and the assertion macro header.
`include "rotary_push_event_classifier_top_macros.svh"

module rpec_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpec_pkg::desc_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output rpec_pkg::q_out_t  head_o
);

  rpec_pkg::desc_t             mem_q [rpec_pkg::QDepth];
  logic [rpec_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rpec_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o      = cnt_q == rpec_pkg::QCntW'(rpec_pkg::QDepth);
  assign head_o.vld  = cnt_q != '0;
  assign head_o.desc = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.vld;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `RPEC_ASSERT_NEVER(a_q_overflow, push_i && full_o, "descriptor pushed into full queue")
  `RPEC_ASSERT_CLK(a_q_cnt_bound, cnt_q <= rpec_pkg::QCntW'(rpec_pkg::QDepth), "queue count out of range")

endmodule

// ===== sv/rpec_back.sv =====
// Back end: expands each descriptor into one to three result items.
// Depends on rpec_pkg and the assertion macro header.
`include "rotary_push_event_classifier_top_macros.svh"

module rpec_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rpec_pkg::q_out_t                        head_i,
  output logic                                    q_pop_o,
  output logic                                    empty_o,
  input  logic                                    pop_i,
  output rpec_pkg::event_e                        event_code_o,
  output logic signed [rpec_pkg::CountW-1:0]      turn_delta_o,
  output logic signed [rpec_pkg::StepsW-1:0]      turn_steps_o,
  output logic                                    last_of_run_o
);

  // descriptor being expanded
  logic                                cur_vld_q, cur_vld_d;
  rpec_pkg::desc_t                     cur_q, cur_d;

  // output register
  logic                                out_vld_q, out_vld_d;
  rpec_pkg::event_e                    out_code_q, out_code_d;
  logic signed [rpec_pkg::CountW-1:0]  out_delta_q, out_delta_d;
  logic signed [rpec_pkg::StepsW-1:0]  out_steps_q, out_steps_d;
  logic                                out_last_q, out_last_d;

  logic                                load;
  rpec_pkg::desc_t                     nxt;
  logic                                gen_last;
  rpec_pkg::event_e                    gen_code;
  logic signed [rpec_pkg::CountW-1:0]  rounded;

  assign load    = cur_vld_q && (!out_vld_q || pop_i);
  assign rounded = cur_q.delta + rpec_pkg::CountW'(cur_q.delta[rpec_pkg::CountW-1]);

  // what remains after emitting the current result
  always_comb begin
    nxt      = cur_q;
    gen_code = cur_q.btn_code;
    if (cur_q.btn_vld) begin
      unique case (cur_q.btn_code)
        rpec_pkg::EV_RELEASED_SHORT,
        rpec_pkg::EV_RELEASED_LONG: nxt.btn_code = rpec_pkg::EV_RELEASED;
        default:                    nxt.btn_vld  = 1'b0;
      endcase
    end else begin
      gen_code = rpec_pkg::EV_TURNED;
      nxt.turn = 1'b0;
    end
    gen_last = !nxt.btn_vld && !nxt.turn;
  end

  assign q_pop_o = head_i.vld && (!cur_vld_q || (load && gen_last));

  always_comb begin
    cur_vld_d   = cur_vld_q;
    cur_d       = cur_q;
    out_vld_d   = out_vld_q;
    out_code_d  = out_code_q;
    out_delta_d = out_delta_q;
    out_steps_d = out_steps_q;
    out_last_d  = out_last_q;
    if (pop_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d   = 1'b1;
      out_code_d  = gen_code;
      out_last_d  = gen_last;
      if (cur_q.btn_vld) begin
        out_delta_d = '0;
        out_steps_d = '0;
      end else begin
        out_delta_d = cur_q.delta;
        out_steps_d = rounded[rpec_pkg::CountW-1:1];
      end
      cur_d     = nxt;
      cur_vld_d = !gen_last;
    end
    if (q_pop_o) begin
      cur_vld_d = 1'b1;
      cur_d     = head_i.desc;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_code_q  <= out_code_d;
    out_delta_q <= out_delta_d;
    out_steps_q <= out_steps_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty_o       = !out_vld_q;
  assign event_code_o  = out_code_q;
  assign turn_delta_o  = out_delta_q;
  assign turn_steps_o  = out_steps_q;
  assign last_of_run_o = out_last_q;

  `RPEC_ASSERT_CLK(a_cur_nonempty, cur_vld_q |-> (cur_q.btn_vld || cur_q.turn), "empty descriptor held")
  `RPEC_ASSERT_CLK(a_btn_no_delta, (out_vld_q && out_code_q != rpec_pkg::EV_TURNED) |-> (out_delta_q == '0 && out_steps_q == '0), "button event carries turn data")

endmodule

// ===== sv/rotary_push_event_classifier_top.sv =====
// Top level of the rotary push event classifier: config registers and wiring.
// Depends on rpec_pkg, rpec_front, rpec_fifo, rpec_back.
//
//  port group       direction  handshake          payload
//  sample in        in         push_i / full_o    now_ms_i, button_level_i, encoder_count_i
//  result out       out        pop_i / empty_o    event_code_o, turn_delta_o, turn_steps_o,
//                                                 last_of_run_o
//  config           in/out     psel/penable/...   paddr, pwdata, prdata
//
// A sample is accepted every cycle while the 4-entry descriptor queue has room.
// The back end emits one result item per cycle while pop_i is high; a sample makes 0 to 2
// results, so sustained throughput is one sample per cycle for those with at most one result.
// A result passes through the queue, the current descriptor register and the output register.
// full_o rises when the queue fills; pop_i stalls the back end, and the front once the queue fills.
// Reset clears button/encoder state, queue and output; registers go to 400 and 800.
module rotary_push_event_classifier_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic [rpec_pkg::TimeW-1:0]             now_ms_i,
  input  logic                                   button_level_i,
  input  logic [rpec_pkg::CountW-1:0]            encoder_count_i,
  output logic                                   empty_o,
  input  logic                                   pop_i,
  output logic [2:0]                             event_code_o,
  output logic signed [rpec_pkg::CountW-1:0]     turn_delta_o,
  output logic signed [rpec_pkg::StepsW-1:0]     turn_steps_o,
  output logic                                   last_of_run_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [rpec_pkg::CfgW-1:0] short_limit_q, dead_time_q;
  logic                      cfg_wr;
  logic                      desc_push;
  rpec_pkg::desc_t           desc;
  rpec_pkg::q_out_t          head;
  logic                      q_pop;
  rpec_pkg::event_e          event_code;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {16'b0, (paddr[2] == rpec_pkg::RegDeadTime) ? dead_time_q : short_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_limit_q <= rpec_pkg::ShortLimitRst;
      dead_time_q   <= rpec_pkg::DeadTimeRst;
    end else if (cfg_wr) begin
      if (paddr[2] == rpec_pkg::RegShortLimit) begin
        short_limit_q <= pwdata[rpec_pkg::CfgW-1:0];
      end else begin
        dead_time_q <= pwdata[rpec_pkg::CfgW-1:0];
      end
    end
  end

  rpec_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_i          (full_o),
    .now_ms_i        (now_ms_i),
    .button_level_i  (button_level_i),
    .encoder_count_i (encoder_count_i),
    .short_limit_i   (short_limit_q),
    .dead_time_i     (dead_time_q),
    .desc_push_o     (desc_push),
    .desc_o          (desc)
  );

  rpec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (desc_push),
    .push_data_i (desc),
    .full_o      (full_o),
    .pop_i       (q_pop),
    .head_o      (head)
  );

  rpec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_pop_o       (q_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .event_code_o  (event_code),
    .turn_delta_o  (turn_delta_o),
    .turn_steps_o  (turn_steps_o),
    .last_of_run_o (last_of_run_o)
  );

  assign event_code_o = event_code;

endmodule

// ===== dv/tb_rotary_push_event_classifier_top.sv =====
// Self-checking testbench for rotary_push_event_classifier_top: press, release and
// turn classification checked item by item against a behavioral predictor.
// Depends on rpec_pkg and the classifier RTL only.
module tb_rotary_push_event_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  // expected events per accepted sample, plus the mismatch counter
  class rotary_event_board;
    typedef struct {
      rpec_pkg::event_e                   code;
      logic signed [rpec_pkg::CountW-1:0] delta;
      logic signed [rpec_pkg::StepsW-1:0] steps;
      logic                               last;
    } event_item_t;

    event_item_t                   pending_events[$];
    int unsigned                   errors;
    logic [rpec_pkg::CfgW-1:0]     short_limit;
    logic [rpec_pkg::CfgW-1:0]     dead_time;
    logic                          held;
    logic [rpec_pkg::TimeW-1:0]    last_change;
    logic [rpec_pkg::TimeW-1:0]    last_edge;
    logic [rpec_pkg::CountW-1:0]   prev_count;

    function new();
      errors      = 0;
      short_limit = rpec_pkg::ShortLimitRst;
      dead_time   = rpec_pkg::DeadTimeRst;
      held        = 1'b0;
      last_change = '0;
      last_edge   = '0;
      prev_count  = '0;
    endfunction

    function void set_register(logic sel, logic [rpec_pkg::CfgW-1:0] value);
      if (sel == rpec_pkg::RegShortLimit) begin
        short_limit = value;
      end else begin
        dead_time = value;
      end
    endfunction

    function int unsigned time_span();
      return 2 * ((short_limit > dead_time) ? short_limit : dead_time) + 20;
    endfunction

    function int unsigned waiting();
      return pending_events.size();
    endfunction

    function void add_event(rpec_pkg::event_e code,
                            logic signed [rpec_pkg::CountW-1:0] delta,
                            logic signed [rpec_pkg::StepsW-1:0] steps);
      event_item_t item;
      item.code  = code;
      item.delta = delta;
      item.steps = steps;
      item.last  = 1'b0;
      pending_events.push_back(item);
    endfunction

    function void classify_sample(logic [rpec_pkg::TimeW-1:0] now, logic level,
                                  logic [rpec_pkg::CountW-1:0] count);
      int unsigned                 first;
      logic [rpec_pkg::TimeW-1:0]  elapsed;
      logic [rpec_pkg::CountW-1:0] raw;
      int                          d;
      first = pending_events.size();
      if (!held && !level) begin
        add_event(rpec_pkg::EV_PRESSED, '0, '0);
        held        = 1'b1;
        last_change = now;
        last_edge   = now;
      end else if (held && level) begin
        elapsed = now - last_change;
        add_event((elapsed < rpec_pkg::TimeW'(short_limit)) ?
                  rpec_pkg::EV_RELEASED_SHORT : rpec_pkg::EV_RELEASED_LONG, '0, '0);
        add_event(rpec_pkg::EV_RELEASED, '0, '0);
        held        = 1'b0;
        last_change = now;
        last_edge   = now;
      end
      if (count != prev_count) begin
        raw         = count - prev_count;
        d           = $signed(raw);
        last_change = now;
        elapsed     = now - last_edge;
        // turns inside the dead time only move the change time
        if (elapsed > rpec_pkg::TimeW'(dead_time))
          add_event(rpec_pkg::EV_TURNED, $signed(raw), rpec_pkg::StepsW'(d / 2));
      end
      prev_count = count;
      if (pending_events.size() > first)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_event(logic [2:0] code, logic signed [rpec_pkg::CountW-1:0] delta,
                     logic signed [rpec_pkg::StepsW-1:0] steps, logic last);
      event_item_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("result code %0d with nothing outstanding", code));
        return;
      end
      want = pending_events.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("event_code %0d, want %s", code, want.code.name()));
      if (delta !== want.delta)
        report_mismatch($sformatf("turn_delta %0d, want %0d", delta, want.delta));
      if (steps !== want.steps)
        report_mismatch($sformatf("turn_steps %0d, want %0d", steps, want.steps));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_run %0b, want %0b", last, want.last));
    endtask
  endclass

  logic                               clk_i           = 1'b0;
  logic                               rst_ni          = 1'b0;
  logic                               push_i          = 1'b0;
  logic                               full_o;
  logic [rpec_pkg::TimeW-1:0]         now_ms_i        = '0;
  logic                               button_level_i  = 1'b1;
  logic [rpec_pkg::CountW-1:0]        encoder_count_i = '0;
  logic                               empty_o;
  logic                               pop_i           = 1'b0;
  logic [2:0]                         event_code_o;
  logic signed [rpec_pkg::CountW-1:0] turn_delta_o;
  logic signed [rpec_pkg::StepsW-1:0] turn_steps_o;
  logic                               last_of_run_o;
  logic                               psel            = 1'b0;
  logic                               penable         = 1'b0;
  logic                               pwrite          = 1'b0;
  logic [2:0]                         paddr           = '0;
  logic [31:0]                        pwdata          = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  rotary_event_board board;
  bit                quiet = 1'b0;  // no idling on either side while set

  logic [rpec_pkg::TimeW-1:0]  cur_now   = '0;
  logic                        cur_level = 1'b1;
  logic [rpec_pkg::CountW-1:0] cur_count = '0;

  rotary_push_event_classifier_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .now_ms_i       (now_ms_i),
    .button_level_i (button_level_i),
    .encoder_count_i(encoder_count_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .event_code_o   (event_code_o),
    .turn_delta_o   (turn_delta_o),
    .turn_steps_o   (turn_steps_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // push stays high after acceptance; callers lower it before idling
  task automatic send_sample(logic [rpec_pkg::TimeW-1:0] now, logic level,
                             logic [rpec_pkg::CountW-1:0] count);
    if (!quiet && $urandom_range(99) < 15) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    push_i          <= 1'b1;
    now_ms_i        <= now;
    button_level_i  <= level;
    encoder_count_i <= count;
    do @(posedge clk_i); while (full_o);
    board.classify_sample(now, level, count);
    cur_now   = now;
    cur_level = level;
    cur_count = count;
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    // results that the predictor did not expect may still come out of the DUT
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(logic sel, logic [rpec_pkg::CfgW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(sel, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value))
      board.report_mismatch($sformatf("register %0d reads %0h, want %0h", sel, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic directed_samples();
    send_sample(32'd0, 1'b1, 16'h0000);
    send_sample(32'd100, 1'b1, 16'h0001);       // turn inside dead time after reset
    send_sample(32'd900, 1'b1, 16'h0003);
    send_sample(32'd1000, 1'b1, 16'h8003);      // most negative delta
    send_sample(32'd2000, 1'b1, 16'h0002);      // most positive delta
    send_sample(32'd3000, 1'b1, 16'h0001);      // -1 halves to zero
    send_sample(32'd3800, 1'b1, 16'hffff);
    send_sample(32'd4000, 1'b0, 16'h0004);      // press and turn together
    send_sample(32'd4100, 1'b0, 16'h0005);      // turn while held, in dead time
    send_sample(32'd4300, 1'b1, 16'h0005);      // short, measured from the turn
    send_sample(32'd5000, 1'b0, 16'h0005);
    send_sample(32'd5400, 1'b1, 16'h0005);      // exactly at the limit: long
    send_sample(32'd6000, 1'b0, 16'h0005);
    send_sample(32'd6399, 1'b1, 16'h0005);
    send_sample(32'd7000, 1'b0, 16'h0005);
    send_sample(32'd7800, 1'b0, 16'h0006);      // exactly at dead time: not reported
    send_sample(32'd7801, 1'b0, 16'h0007);      // turn while held
    send_sample(32'd7900, 1'b1, 16'h0009);      // release with a silent turn
    send_sample(32'd7000, 1'b1, 16'h000a);      // clock went backwards
    send_sample(32'hffff_ff00, 1'b0, 16'h000a);
    send_sample(32'h0000_0010, 1'b1, 16'h000a); // release across the time wrap
    send_sample(32'hffff_ffff, 1'b1, 16'hffff);
    send_sample(32'h8000_0000, 1'b0, 16'h7fff);
    send_sample(32'h8000_0000, 1'b0, 16'h7fff);
  endtask

  // press/hold/release sequences with jittered time and encoder motion
  task automatic random_samples(int unsigned n_items);
    int unsigned                 pick;
    int unsigned                 span;
    logic [rpec_pkg::TimeW-1:0]  now;
    logic                        level;
    logic [rpec_pkg::CountW-1:0] count;
    span = board.time_span();
    for (int i = 0; i < n_items; i++) begin
      now   = cur_now;
      level = cur_level;
      count = cur_count;
      pick  = $urandom_range(99);
      if (pick < 65)
        now = now + $urandom_range(0, span);
      else if (pick >= 75 && pick < 85)
        now = now - $urandom_range(1, 2000);
      else if (pick >= 85 && pick < 92)
        now = $urandom;
      else if (pick >= 92)
        now = now + $urandom_range(0, 32'h00ff_ffff);
      pick = $urandom_range(99);
      if (pick < 10)
        level = 1'($urandom);
      else if (pick < 35)
        level = ~level;
      pick = $urandom_range(99);
      if (pick >= 45 && pick < 65)
        count = count + 16'($urandom_range(1, 4));
      else if (pick >= 65 && pick < 85)
        count = count - 16'($urandom_range(1, 4));
      else if (pick >= 85 && pick < 95)
        count = 16'($urandom);
      else if (pick >= 95)
        count = count + 16'h8000;
      send_sample(now, level, count);
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o)
        board.check_event(event_code_o, turn_delta_o, turn_steps_o, last_of_run_o);
      if (quiet) begin
        pop_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        pop_i <= 1'b0;
      end else if ($urandom_range(99) < 12) begin
        // now and then a longer stall so the queue fills up
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(3, 10) : 0;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_register(rpec_pkg::RegShortLimit, rpec_pkg::ShortLimitRst);
    write_register(rpec_pkg::RegDeadTime, rpec_pkg::DeadTimeRst);
    directed_samples();
    random_samples(50);
    wait_drained();

    write_register(rpec_pkg::RegShortLimit, 16'd0);
    write_register(rpec_pkg::RegDeadTime, 16'd0);
    random_samples(40);
    wait_drained();

    write_register(rpec_pkg::RegShortLimit, 16'hffff);
    write_register(rpec_pkg::RegDeadTime, 16'hffff);
    random_samples(30);
    wait_drained();

    write_register(rpec_pkg::RegShortLimit, 16'($urandom_range(1, 2000)));
    write_register(rpec_pkg::RegDeadTime, 16'($urandom_range(1, 2000)));
    random_samples(15);
    quiet = 1'b1;
    random_samples(50);
    quiet = 1'b0;
    random_samples(15);
    wait_drained();

    write_register(rpec_pkg::RegShortLimit, 16'd1);
    write_register(rpec_pkg::RegDeadTime, 16'd1);
    random_samples(30);
    wait_drained();

    write_register(rpec_pkg::RegShortLimit, 16'($urandom));
    write_register(rpec_pkg::RegDeadTime, 16'($urandom_range(0, 300)));
    random_samples(30);
    wait_drained();

    if (board.errors == 0) begin
      $display("rotary_push_event_classifier_top regression: pass");
    end else begin
      $display("rotary_push_event_classifier_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("rotary_push_event_classifier_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rpec_pkg.sv
sv/rpec_front.sv
sv/rpec_fifo.sv
sv/rpec_back.sv
sv/rotary_push_event_classifier_top.sv
dv/tb_rotary_push_event_classifier_top.sv
